@@ rtl/goflp_pkg.sv @@
// ----------------------------------------------------------------------------
// goflp_pkg
// Shared types, constants and counter helpers for the gshare off-chip load
// predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package goflp_pkg;

  // Global history length; the pattern table has 2^HISTORY_BITS counters.
  localparam int HISTORY_BITS = 12;
  localparam int TABLE_DEPTH  = 1 << HISTORY_BITS;
  localparam int PC_HASH_W    = 12;
  localparam int CTR_W        = 2;

  typedef logic [HISTORY_BITS-1:0] idx_t;
  typedef logic [PC_HASH_W-1:0]    pc_hash_t;
  typedef logic [CTR_W-1:0]        ctr_t;

  typedef enum logic {
    FUNC_PREDICT = 1'b0,
    FUNC_TRAIN   = 1'b1
  } func_t;

  localparam ctr_t CTR_STRONG_NOT = ctr_t'(0);
  localparam ctr_t CTR_WEAK_TAKEN = ctr_t'(2);
  localparam ctr_t CTR_MAX        = ctr_t'(3);

  // Table index: hash bits above the history width drop out, and history
  // bits above the hash width pass through alone.
  function automatic idx_t make_index(input pc_hash_t pc_hash, input idx_t hist);
    idx_t ext;
    for (int i = 0; i < HISTORY_BITS; i++) begin
      ext[i] = (i < PC_HASH_W) ? pc_hash[i % PC_HASH_W] : 1'b0;
    end
    return ext ^ hist;
  endfunction

  // Saturating step toward the observed outcome.
  function automatic ctr_t ctr_train(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + ctr_t'(1);
    end else begin
      if (ctr != CTR_STRONG_NOT) res = ctr - ctr_t'(1);
    end
    return res;
  endfunction

  // Weakly or strongly taken means an off-chip guess.
  function automatic logic ctr_guess(input ctr_t ctr);
    return (ctr >= CTR_WEAK_TAKEN);
  endfunction

endpackage

`default_nettype wire

@@ rtl/goflp_ram.sv @@
// ----------------------------------------------------------------------------
// goflp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. A read at the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module goflp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/gshare_offchip_load_predictor.sv @@
// ----------------------------------------------------------------------------
// gshare_offchip_load_predictor
// Gshare predictor with 2-bit saturating counters that guesses whether a load
// goes off chip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accept: func
//   selects predict or train, pc_hash is the folded load PC, offchip_outcome
//   is the observed outcome (used by train only). An item is taken at a rising
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns offchip_guess for each
//   predict item, in order. Train items produce nothing.
//   Throughput: one item per cycle while in_stall is low. A predict passes
//   through the table read and then the result register before its guess
//   shows on out_valid. The table read port is registered, so a train that
//   writes a counter in the same cycle a following item reads it is
//   forwarded from a last-write register.
//   The global history advances when a train is accepted, so the next item
//   already indexes with the updated history.
//   Reset: history clears, then a clearing pass writes every counter to
//   weakly taken, one entry per cycle over all 2^HISTORY_BITS entries,
//   during which in_stall is held high.
//   Stall: while out_stall holds a waiting guess, one predict can wait in the
//   read stage behind it, and in_stall stays high until the guess leaves.
//   Trains leave the read stage at once and never wait on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gshare_offchip_load_predictor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic [goflp_pkg::PC_HASH_W-1:0] pc_hash,
  input  logic                         offchip_outcome,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         offchip_guess
);

  import goflp_pkg::*;

  // Clearing pass after reset
  logic clearing;
  idx_t clear_addr;

  // Global history
  idx_t history;

  // Read stage: item waiting on table data
  logic  s1_valid;
  func_t s1_func;
  idx_t  s1_idx;
  logic  s1_taken;

  // Most recent table write, for forwarding over the read port
  logic lastwr_valid;
  idx_t lastwr_addr;
  ctr_t lastwr_data;

  // Table port signals
  logic ram_wr_en;
  idx_t ram_wr_addr;
  ctr_t ram_wr_data;
  ctr_t ram_rd_data;

  logic in_accept;
  logic s1_move;
  logic s1_write;
  idx_t in_idx;
  ctr_t s1_ctr;
  ctr_t s1_ctr_next;

  assign in_idx = make_index(pc_hash, history);

  // The read stage holds only a predict that cannot enter a full, stalled
  // result register.
  assign s1_move   = s1_valid && ((s1_func == FUNC_TRAIN) || !out_valid || !out_stall);
  assign in_stall  = clearing || (s1_valid && !s1_move);
  assign in_accept = in_valid && !in_stall;
  assign s1_write  = s1_move && (s1_func == FUNC_TRAIN);

  // Forward the last write when it hit the same counter.
  assign s1_ctr = (lastwr_valid && (lastwr_addr == s1_idx)) ? lastwr_data : ram_rd_data;
  assign s1_ctr_next = ctr_train(s1_ctr, s1_taken);

  always_comb begin
    if (clearing) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clear_addr;
      ram_wr_data = CTR_WEAK_TAKEN;
    end else begin
      ram_wr_en   = s1_write;
      ram_wr_addr = s1_idx;
      ram_wr_data = s1_ctr_next;
    end
  end

  goflp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (ram_rd_data)
  );

  // Clearing pass: sweep every entry once, then open the input.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + idx_t'(1);
      if (clear_addr == idx_t'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Shift the outcome into history as soon as the train is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (in_accept && (func_t'(func) == FUNC_TRAIN)) begin
      history <= {history[HISTORY_BITS-2:0], offchip_outcome};
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func  <= func_t'(func);
      s1_idx   <= in_idx;
      s1_taken <= offchip_outcome;
    end
  end

  // Record each counter update.
  always_ff @(posedge clk) begin
    if (rst) begin
      lastwr_valid <= 1'b0;
    end else if (s1_write) begin
      lastwr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      lastwr_addr <= s1_idx;
      lastwr_data <= s1_ctr_next;
    end
  end

  // Result register: load a predict, drop a taken guess.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && (s1_func == FUNC_PREDICT)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && (s1_func == FUNC_PREDICT)) begin
      offchip_guess <= ctr_guess(s1_ctr);
    end
  end

endmodule

`default_nettype wire

@@ rtl/goflp_checker.sv @@
// ----------------------------------------------------------------------------
// goflp_checker
// Port-level checks for the gshare off-chip load predictor, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module goflp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic func,
  input logic out_valid,
  input logic out_stall,
  input logic offchip_guess
);

  import goflp_pkg::*;

  // The clearing pass blocks input right after reset.
  a_stall_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

  // A new guess rises only from an accepted predict, via the read stage and result register.
  a_guess_from_predict: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (func == FUNC_PREDICT), 2))
    else $error("guess without a predict two cycles earlier");

  // A train never brings up a guess.
  a_train_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (func == FUNC_TRAIN)) |-> ##2 !$rose(out_valid))
    else $error("train produced a result");

  // A stalled guess holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(offchip_guess)))
    else $error("stalled guess changed");

endmodule

bind gshare_offchip_load_predictor goflp_checker u_goflp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .func          (func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .offchip_guess (offchip_guess)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gshare off-chip load predictor. A local copy
// of the history register and counter table predicts every guess, and each
// guess is checked in order as it leaves the block. Senders and receivers
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import goflp_pkg::*;

  // No accept on either channel for this long means the block is hung.
  // Covers the post-reset clearing pass with a wide margin.
  localparam int IDLE_LIMIT   = 20000;
  // Edges to settle after the last guess comes back, before a pause ends.
  localparam int SETTLE_EDGES = 8;
  localparam int HOT_LOADS    = 6;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_LONG,
    STALL_HEAVY
  } stall_mode_t;

  logic     clk             = 1'b0;
  logic     rst             = 1'b1;
  logic     in_valid        = 1'b0;
  logic     in_stall;
  func_t    cmd             = FUNC_PREDICT;
  pc_hash_t pc_hash         = '0;
  logic     offchip_outcome = 1'b0;
  logic     out_valid;
  logic     out_stall       = 1'b0;
  logic     offchip_guess;

  // Local image of the predictor state and the guesses still in flight.
  ctr_t     conf_ctr [TABLE_DEPTH];
  idx_t     ghist;
  logic     guess_q [$];
  int       errors;

  // Sender pacing: items left in the current burst.
  int       burst_left;

  // Hot loads: fixed table slots that are hit again and again, each with
  // its own off-chip bias out of 8.
  idx_t     hot_idx  [HOT_LOADS];
  int       hot_bias [HOT_LOADS];

  gshare_offchip_load_predictor u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (cmd),
    .pc_hash         (pc_hash),
    .offchip_outcome (offchip_outcome),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .offchip_guess   (offchip_guess)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor image
  // --------------------------------------------------------------------------

  // Apply one accepted access to the local state. A predict queues the
  // guess (counter in a taken state means the top bit is set); a train
  // steps the counter toward the outcome and shifts the outcome into the
  // history.
  function automatic void apply_access(input func_t f, input pc_hash_t h,
                                       input logic outcome);
    idx_t ix;
    ctr_t c;
    ix = idx_t'(h) ^ ghist;
    c  = conf_ctr[ix];
    if (f == FUNC_PREDICT) begin
      guess_q.push_back(c[CTR_W-1]);
    end else begin
      if (outcome && c != CTR_MAX) begin
        c = c + ctr_t'(1);
      end else if (!outcome && c != CTR_STRONG_NOT) begin
        c = c - ctr_t'(1);
      end
      conf_ctr[ix] = c;
      ghist = {ghist[HISTORY_BITS-2:0], outcome};
    end
  endfunction

  // Hash that lands on a given table slot under the current history.
  function automatic pc_hash_t hash_for(input idx_t slot);
    return pc_hash_t'(slot ^ ghist);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Valid stays high
  // on return so back-to-back items go out without a bubble.
  task automatic send_item(input func_t f, input pc_hash_t h, input logic outcome);
    in_valid        <= 1'b1;
    cmd             <= f;
    pc_hash         <= h;
    offchip_outcome <= outcome;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_access(f, h, outcome);
  endtask

  // Open a random gap between bursts; mostly short, sometimes none, and now
  // and then a long gap-free stretch.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Drop valid and hold off until every guess has come back.
  task automatic wait_for_guesses();
    in_valid <= 1'b0;
    while (guess_q.size() != 0) @(posedge clk);
    repeat (SETTLE_EDGES) @(posedge clk);
  endtask

  // Random traffic: hot_pct percent of items hit a hot load slot with its
  // biased outcome, the rest use an arbitrary hash and outcome.
  task automatic run_traffic(input int n, input int hot_pct, input int train_pct);
    int       k;
    func_t    f;
    pc_hash_t h;
    logic     outcome;
    for (int i = 0; i < n; i++) begin
      pace_sender();
      f = ($urandom_range(0, 99) < train_pct) ? FUNC_TRAIN : FUNC_PREDICT;
      if ($urandom_range(0, 99) < hot_pct) begin
        k       = $urandom_range(0, HOT_LOADS - 1);
        h       = hash_for(hot_idx[k]);
        outcome = ($urandom_range(0, 7) < hot_bias[k]);
      end else begin
        h       = pc_hash_t'($urandom);
        outcome = 1'($urandom_range(0, 1));
      end
      send_item(f, h, outcome);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every counter starts weakly taken: predicts across the hash range say 1.
  task automatic test_reset_values();
    send_item(FUNC_PREDICT, '0, 1'b0);
    send_item(FUNC_PREDICT, '1, 1'b1);
    send_item(FUNC_PREDICT, pc_hash_t'(12'h555), 1'b0);
    send_item(FUNC_PREDICT, pc_hash_t'(12'hAAA), 1'b1);
  endtask

  // Walk one counter to both ends and push past them. Trains and predicts go
  // back to back, so the guesses also exercise the write forwarding path.
  task automatic test_counter_saturation();
    idx_t slot;
    slot = idx_t'(12'h5A3);
    repeat (3) send_item(FUNC_TRAIN, hash_for(slot), 1'b1);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b0);
    repeat (4) send_item(FUNC_TRAIN, hash_for(slot), 1'b0);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b1);
    send_item(FUNC_TRAIN, hash_for(slot), 1'b1);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b0);
    send_item(FUNC_TRAIN, hash_for(slot), 1'b1);
    send_item(FUNC_PREDICT, '1, 1'b0);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b0);
  endtask

  // Outcome on a predict must not move the history or the counter.
  task automatic test_predict_ignores_outcome();
    idx_t slot;
    slot = idx_t'(12'h0FF);
    send_item(FUNC_TRAIN, hash_for(slot), 1'b0);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b1);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b1);
    send_item(FUNC_TRAIN, '1, 1'b1);
    send_item(FUNC_PREDICT, hash_for(slot), 1'b0);
  endtask

  // Mostly hot loads with mixed predicts and trains; counters saturate.
  task automatic test_hot_loads();
    for (int k = 0; k < HOT_LOADS; k++) begin
      hot_idx[k]  = idx_t'($urandom);
      hot_bias[k] = $urandom_range(0, 8);
    end
    hot_bias[0] = 0;
    hot_bias[1] = 8;
    run_traffic(700, 80, 50);
  endtask

  // Mostly arbitrary hashes: wide spread over the table.
  task automatic test_mixed_traffic();
    run_traffic(500, 20, 50);
  endtask

  // Long train runs with sparse predicts; history turns over fully.
  task automatic test_train_streaks();
    for (int k = 0; k < HOT_LOADS; k++) hot_bias[k] = $urandom_range(0, 8);
    run_traffic(220, 90, 85);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    errors     = 0;
    burst_left = 0;
    ghist      = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) conf_ctr[i] = CTR_WEAK_TAKEN;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The block holds in_stall through its clearing pass; send_item waits it out.
    test_reset_values();
    test_counter_saturation();
    test_predict_ignores_outcome();
    test_hot_loads();
    wait_for_guesses();
    test_mixed_traffic();
    wait_for_guesses();
    test_train_streaks();
    wait_for_guesses();

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern whose character changes at random from phase to phase,
  // including stretches with no stall at all.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run  = 0;
  int          phase_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(40, 300);
      end else begin
        phase_left--;
      end
      if (stall_run != 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_LONG: begin
            if ($urandom_range(0, 11) == 0) begin
              stall_run = $urandom_range(1, 8);
              out_stall <= 1'b1;
            end else begin
              out_stall <= 1'b0;
            end
          end
          default:     out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Guess checker: compare each accepted guess against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : guess_check
    logic exp_guess;
    if (!rst && out_valid && !out_stall) begin
      if (guess_q.size() == 0) begin
        errors++;
        $display("%0t: offchip_guess expected none actual %0b", $time, offchip_guess);
      end else begin
        exp_guess = guess_q.pop_front();
        if (offchip_guess !== exp_guess) begin
          errors++;
          $display("%0t: offchip_guess expected %0b actual %0b",
                   $time, exp_guess, offchip_guess);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
